@@ rtl/ipav_pkg.sv @@
// ----------------------------------------------------------------------------
// ipav_pkg
// Shared types and constants of the IP address text validator.
// ----------------------------------------------------------------------------
package ipav_pkg;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_CHAR   = 3'd1,
    ERR_LONG   = 3'd2,
    ERR_MANY   = 3'd3,
    ERR_DOUBLE = 3'd4,
    ERR_PLACE  = 3'd5,
    ERR_OCTET  = 3'd6,
    ERR_FEW    = 3'd7
  } ipav_err_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [8:0] OCTET_MAX      = 9'd255;
  localparam logic [8:0] OCTET_OVER     = 9'd256;
  localparam logic [8:0] OCTET_NONDEC   = 9'd511;
  localparam logic [2:0] HEX_GROUP_MAX  = 3'd4;
  localparam logic [3:0] GROUP_CLOSED_MAX = 4'd7;
  localparam logic [3:0] GROUPS_FULL    = 4'd8;
  localparam logic [1:0] OCTET_DIGITS_MAX = 2'd3;
  localparam logic [1:0] DOTS_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0] hex_digit_count;
    logic [3:0] group_count;
    logic       double_colon_seen;
    logic       previous_was_colon;
    logic [8:0] octet_value;
    logic [1:0] octet_digit_count;
    logic [1:0] dot_count;
    logic       in_ipv4_part;
    logic       at_string_start;
    logic       pair_closed;
    ipav_err_t  latched_error;
  } ipav_state_t;

  typedef struct packed {
    logic       address_valid;
    logic [2:0] error_kind;
  } ipav_result_t;

  localparam ipav_state_t IPAV_CLEAR = '{
    hex_digit_count:    3'd0,
    group_count:        4'd0,
    double_colon_seen:  1'b0,
    previous_was_colon: 1'b0,
    octet_value:        9'd0,
    octet_digit_count:  2'd0,
    dot_count:          2'd0,
    in_ipv4_part:       1'b0,
    at_string_start:    1'b1,
    pair_closed:        1'b0,
    latched_error:      ERR_NONE
  };

endpackage

@@ rtl/ipav_char_if.sv @@
// ----------------------------------------------------------------------------
// ipav_char_if
// Character stream channel: one address character per word.
// ----------------------------------------------------------------------------
interface ipav_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/ipav_result_if.sv @@
// ----------------------------------------------------------------------------
// ipav_result_if
// Verdict channel: one word per checked address string.
// ----------------------------------------------------------------------------
interface ipav_result_if;
  logic       valid;
  logic       ready;
  logic       address_valid;
  logic [2:0] error_kind;

  modport source (output valid, output address_valid, output error_kind, input ready);
  modport sink   (input valid, input address_valid, input error_kind, output ready);
endinterface

@@ rtl/ipav_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ipav_cfg_if
// Configuration write channel for the mode register.
// ----------------------------------------------------------------------------
interface ipav_cfg_if;
  logic valid;
  logic ready;
  logic address_mode;

  modport source (output valid, output address_mode, input ready);
  modport sink   (input valid, input address_mode, output ready);
endinterface

@@ rtl/ipav_step.sv @@
// ----------------------------------------------------------------------------
// ipav_step
// Per-character next-state logic and end-of-string verdict.
// ----------------------------------------------------------------------------
module ipav_step
  import ipav_pkg::*;
(
  input  ipav_state_t  cur,
  input  logic         address_mode,
  input  logic [7:0]   char_code,
  input  logic         is_last,
  output ipav_state_t  next,
  output ipav_result_t verdict
);

  logic        is_dec;
  logic        is_hex;
  logic [12:0] dec_acc;
  ipav_state_t dot_n;
  ipav_state_t chr_n;
  ipav_state_t fin;
  logic [3:0]  groups;

  assign is_dec = (char_code >= CH_0) && (char_code <= CH_9);
  assign is_hex = is_dec
               || ((char_code >= CH_LA) && (char_code <= CH_LF))
               || ((char_code >= CH_UA) && (char_code <= CH_UF));

  // value*10 + digit; decimal low nibble is the digit
  assign dec_acc = ({4'd0, cur.octet_value} << 3) + ({4'd0, cur.octet_value} << 1)
                 + {9'd0, char_code[3:0]};

  // dotted-quad character handling
  always_comb begin
    dot_n = cur;
    if (is_dec) begin
      if (cur.octet_digit_count == OCTET_DIGITS_MAX) begin
        dot_n.latched_error = ERR_LONG;
      end else if (dec_acc > {4'd0, OCTET_MAX}) begin
        dot_n.latched_error = ERR_OCTET;
      end else begin
        dot_n.octet_value       = dec_acc[8:0];
        dot_n.octet_digit_count = cur.octet_digit_count + 2'd1;
      end
    end else if (char_code == CH_DOT) begin
      if (cur.octet_digit_count == 2'd0) begin
        dot_n.latched_error = ERR_PLACE;
      end else if (cur.dot_count == DOTS_FULL) begin
        dot_n.latched_error = ERR_MANY;
      end else begin
        dot_n.dot_count         = cur.dot_count + 2'd1;
        dot_n.octet_value       = 9'd0;
        dot_n.octet_digit_count = 2'd0;
      end
    end else begin
      dot_n.latched_error = ERR_CHAR;
    end
  end

  // character update; errors are sticky
  always_comb begin
    chr_n = cur;
    if (cur.latched_error == ERR_NONE) begin
      if (!address_mode) begin
        chr_n = dot_n;
      end else if (cur.in_ipv4_part) begin
        if (char_code == CH_COLON) chr_n.latched_error = ERR_PLACE;
        else                       chr_n = dot_n;
      end else if (cur.at_string_start && cur.previous_was_colon
                   && (char_code != CH_COLON)) begin
        chr_n.latched_error = ERR_PLACE;
      end else if (is_hex) begin
        if (cur.hex_digit_count == HEX_GROUP_MAX) begin
          chr_n.latched_error = ERR_LONG;
        end else begin
          chr_n.hex_digit_count = cur.hex_digit_count + 3'd1;
          // octet_value tracks whether the group could open a dotted tail
          if (!is_dec) begin
            chr_n.octet_value = OCTET_NONDEC;
          end else if (cur.octet_value <= OCTET_MAX) begin
            chr_n.octet_value = (dec_acc > {4'd0, OCTET_MAX}) ? OCTET_OVER : dec_acc[8:0];
          end
          chr_n.previous_was_colon = 1'b0;
          chr_n.pair_closed        = 1'b0;
          chr_n.at_string_start    = 1'b0;
        end
      end else if (char_code == CH_COLON) begin
        if (cur.previous_was_colon) begin
          if (cur.pair_closed) begin
            chr_n.latched_error = ERR_PLACE;
          end else if (cur.double_colon_seen) begin
            chr_n.latched_error = ERR_DOUBLE;
          end else begin
            chr_n.double_colon_seen = 1'b1;
            chr_n.pair_closed       = 1'b1;
            chr_n.at_string_start   = 1'b0;
          end
        end else if (cur.at_string_start) begin
          chr_n.previous_was_colon = 1'b1;
        end else if (cur.group_count >= GROUP_CLOSED_MAX) begin
          chr_n.latched_error = ERR_MANY;
        end else begin
          chr_n.group_count        = cur.group_count + 4'd1;
          chr_n.hex_digit_count    = 3'd0;
          chr_n.octet_value        = 9'd0;
          chr_n.previous_was_colon = 1'b1;
        end
      end else if (char_code == CH_DOT) begin
        if (cur.hex_digit_count == 3'd0) begin
          chr_n.latched_error = ERR_PLACE;
        end else if (cur.octet_value == OCTET_NONDEC) begin
          chr_n.latched_error = ERR_CHAR;
        end else if (cur.hex_digit_count == HEX_GROUP_MAX) begin
          chr_n.latched_error = ERR_LONG;
        end else if (cur.octet_value > OCTET_MAX) begin
          chr_n.latched_error = ERR_OCTET;
        end else begin
          chr_n.in_ipv4_part      = 1'b1;
          chr_n.dot_count         = 2'd1;
          chr_n.octet_value       = 9'd0;
          chr_n.octet_digit_count = 2'd0;
        end
      end else begin
        chr_n.latched_error = ERR_CHAR;
      end
    end
  end

  // end-of-string checks
  always_comb begin
    fin    = chr_n;
    groups = 4'd0;
    if (address_mode) begin
      if (chr_n.in_ipv4_part) begin
        groups = chr_n.group_count + 4'd2;
      end else begin
        groups = chr_n.group_count + {3'd0, (chr_n.hex_digit_count != 3'd0)};
      end
    end
    if (is_last && (chr_n.latched_error == ERR_NONE)) begin
      if (!address_mode || chr_n.in_ipv4_part) begin
        if (chr_n.octet_digit_count == 2'd0)  fin.latched_error = ERR_PLACE;
        else if (chr_n.dot_count < DOTS_FULL) fin.latched_error = ERR_FEW;
      end else if (chr_n.previous_was_colon && !chr_n.pair_closed) begin
        fin.latched_error = ERR_PLACE;
      end
      if (address_mode && (fin.latched_error == ERR_NONE)) begin
        if (chr_n.double_colon_seen) begin
          if (groups > GROUP_CLOSED_MAX) fin.latched_error = ERR_MANY;
        end else if (groups > GROUPS_FULL) begin
          fin.latched_error = ERR_MANY;
        end else if (groups < GROUPS_FULL) begin
          fin.latched_error = ERR_FEW;
        end
      end
    end
  end

  assign verdict.address_valid = (fin.latched_error == ERR_NONE);
  assign verdict.error_kind    = fin.latched_error;
  assign next                  = is_last ? IPAV_CLEAR : chr_n;

endmodule

@@ rtl/ip_address_text_validator.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_validator
// Streaming IPv4 / IPv6 address text checker with a one-word verdict.
// ----------------------------------------------------------------------------
// Takes one character word per cycle on chars and checks the string as it
// arrives; the word marked is_last produces one verdict word on result
// (address_valid plus error_kind, first error wins). A new character is
// accepted every cycle while chars.ready is high; the verdict is registered
// into the output register, or into the skid entry while that word is
// stalled. A two-entry result buffer (output register plus skid) keeps chars
// flowing while a verdict waits; chars.ready drops only when both entries are
// held. Register address_mode (reset 1): 0 checks a dotted quad, 1 checks
// IPv6 with an optional dotted tail. A write also discards any partial string,
// and is meant to happen only while no string is in flight.
module ip_address_text_validator
  import ipav_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ipav_cfg_if.sink      cfg,
  ipav_char_if.sink     chars,
  ipav_result_if.source result
);

  logic         address_mode;
  ipav_state_t  st;
  ipav_state_t  st_next;
  ipav_result_t verdict;

  // output register and skid entry
  logic         out_valid;
  ipav_result_t out_word;
  logic         skid_valid;
  ipav_result_t skid_word;

  logic cfg_wr;
  logic char_acc;
  logic push;
  logic pop;

  assign cfg.ready   = 1'b1;
  assign chars.ready = !skid_valid;

  assign cfg_wr   = cfg.valid && cfg.ready;
  assign char_acc = chars.valid && chars.ready;
  assign push     = char_acc && chars.is_last && !cfg_wr;
  assign pop      = out_valid && result.ready;

  ipav_step u_step (
    .cur          (st),
    .address_mode (address_mode),
    .char_code    (chars.char_code),
    .is_last      (chars.is_last),
    .next         (st_next),
    .verdict      (verdict)
  );

  // string state and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      address_mode <= 1'b1;
      st           <= IPAV_CLEAR;
    end else if (cfg_wr) begin
      address_mode <= cfg.address_mode;
      st           <= IPAV_CLEAR;
    end else if (char_acc) begin
      st <= st_next;
    end
  end

  // result buffer; skid fills only when the output word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_word  <= verdict;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= verdict;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.address_valid = out_word.address_valid;
  assign result.error_kind    = out_word.error_kind;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output word");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.address_valid == (out_word.error_kind == ERR_NONE)))
    else $error("address_valid disagrees with error_kind");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.latched_error != ERR_NONE && !cfg_wr && !(char_acc && chars.is_last))
    |=> $stable(st.latched_error))
    else $error("latched error changed within a string");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (char_acc && chars.is_last) |=>
      (st.at_string_start && st.latched_error == ERR_NONE
       && st.group_count == 4'd0 && !st.in_ipv4_part))
    else $error("string state not cleared after last character");

  a_hex_count_range: assert property (@(posedge clk) disable iff (rst)
    st.hex_digit_count <= HEX_GROUP_MAX)
    else $error("hex digit count out of range");

endmodule
